// ===== rtl/aimad_pkg.sv =====
// ----------------------------------------------------------------------------
// aimad_pkg
// Shared constants and binary32 helpers for the attribute interpolation core.
// ----------------------------------------------------------------------------
package aimad_pkg;

  localparam logic [31:0] QNAN_DEFAULT = 32'h7FC0_0000;
  localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;
  localparam logic [7:0]  EXP_MAX      = 8'hFF;

  function automatic logic is_nan(input logic [31:0] x);
    return (x[30:23] == EXP_MAX) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [31:0] x);
    return (x[30:23] == EXP_MAX) && (x[22:0] == 23'd0);
  endfunction

  function automatic logic is_zero(input logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  // leading zero count over 64 bits, 64 for an all-zero word
  function automatic logic [6:0] lzc64(input logic [63:0] x);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) n = 7'(63 - i);
    end
    return n;
  endfunction

  // sig has its leading one at bit 62 (or is zero); e is the biased exponent
  // of that leading one, may be below one for denormal results
  function automatic logic [31:0] round_pack(input logic sgn,
                                             input logic signed [11:0] e,
                                             input logic [63:0] sig);
    logic [5:0]         sh;
    logic [63:0]        sft;
    logic [63:0]        mask;
    logic [24:0]        m;
    logic               g;
    logic               st;
    logic signed [11:0] ef;
    logic [31:0]        r;
    sh   = 6'd39;
    sft  = 64'd0;
    mask = 64'd0;
    m    = 25'd0;
    g    = 1'b0;
    st   = 1'b0;
    ef   = e;
    r    = {sgn, 31'd0};
    if (sig != 64'd0 && e >= -12'sd23) begin
      sh   = (e >= 12'sd1) ? 6'd39 : 6'(12'sd40 - e);
      sft  = sig >> (sh - 6'd1);
      g    = sft[0];
      m    = {1'b0, sft[24:1]};
      mask = (64'd1 << (sh - 6'd1)) - 64'd1;
      st   = (sig & mask) != 64'd0;
      if (g && (st || m[0])) m = m + 25'd1;
      if (e < 12'sd1) begin
        r = {sgn, 7'd0, m[23:0]};
      end else begin
        if (m[24]) begin
          m  = m >> 1;
          ef = ef + 12'sd1;
        end
        if (ef >= 12'sd255) r = {sgn, EXP_MAX, 23'd0};
        else                r = {sgn, ef[7:0], m[22:0]};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/attribute_interp_mul_add_core.sv =====
// ----------------------------------------------------------------------------
// attribute_interp_mul_add_core
// Binary32 coef*s rounded, then added to base or previous destination.
// ----------------------------------------------------------------------------
// throughput: one item per cycle while not stalled; stages: multiply, product normalize,
//   product round, align, add, sum normalize, sum round
// each stage holds its own item under stall, bubbles are squeezed out
// reset clears the stage valid bits only
module attribute_interp_mul_add_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic        command_i,
  input  logic [31:0] bary_s_i,
  input  logic [31:0] attr_base_i,
  input  logic [31:0] attr_coef_i,
  input  logic [31:0] dest_prev_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] result_o
);

  logic [7:1] v_q;
  logic [8:1] rdy;

  assign rdy[8] = !stall_i;
  always_comb begin
    for (int k = 1; k <= 7; k++) rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign stall_o = !rdy[1];
  assign valid_o = v_q[7];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[1]) v_q[1] <= valid_i;
      for (int k = 2; k <= 7; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 1: multiply
  logic        sp1_d;
  logic [31:0] spv1_d;
  logic [23:0] ma1, mb1;
  logic [7:0]  ea1, eb1;
  logic        cmd1_q, sgn1_q, sp1_q;
  logic [31:0] base1_q, prev1_q, spv1_q;
  logic [47:0] p1_q;
  logic [9:0]  esum1_q;

  always_comb begin
    ma1    = {attr_coef_i[30:23] != 8'd0, attr_coef_i[22:0]};
    mb1    = {bary_s_i[30:23] != 8'd0, bary_s_i[22:0]};
    ea1    = (attr_coef_i[30:23] == 8'd0) ? 8'd1 : attr_coef_i[30:23];
    eb1    = (bary_s_i[30:23] == 8'd0) ? 8'd1 : bary_s_i[30:23];
    sp1_d  = 1'b1;
    spv1_d = {attr_coef_i[31] ^ bary_s_i[31], 31'd0};
    priority if (aimad_pkg::is_nan(attr_coef_i)) begin
      spv1_d = attr_coef_i | aimad_pkg::QUIET_BIT;
    end else if (aimad_pkg::is_nan(bary_s_i)) begin
      spv1_d = bary_s_i | aimad_pkg::QUIET_BIT;
    end else if (aimad_pkg::is_inf(attr_coef_i) || aimad_pkg::is_inf(bary_s_i)) begin
      if (aimad_pkg::is_zero(attr_coef_i) || aimad_pkg::is_zero(bary_s_i))
        spv1_d = aimad_pkg::QNAN_DEFAULT;
      else
        spv1_d = {attr_coef_i[31] ^ bary_s_i[31], aimad_pkg::EXP_MAX, 23'd0};
    end else if (aimad_pkg::is_zero(attr_coef_i) || aimad_pkg::is_zero(bary_s_i)) begin
      spv1_d = {attr_coef_i[31] ^ bary_s_i[31], 31'd0};
    end else begin
      sp1_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1] && valid_i) begin
      cmd1_q  <= command_i;
      base1_q <= attr_base_i;
      prev1_q <= dest_prev_i;
      sgn1_q  <= attr_coef_i[31] ^ bary_s_i[31];
      sp1_q   <= sp1_d;
      spv1_q  <= spv1_d;
      p1_q    <= ma1 * mb1;
      esum1_q <= {2'b0, ea1} + {2'b0, eb1};
    end
  end

  // stage 2: product normalize
  logic [6:0]         lz2;
  logic [5:0]         lz48;
  logic               cmd2_q, sgn2_q, sp2_q;
  logic [31:0]        base2_q, prev2_q, spv2_q;
  logic [63:0]        n2_q;
  logic signed [11:0] e2_q;

  assign lz2  = aimad_pkg::lzc64({16'd0, p1_q}) - 7'd16;
  assign lz48 = lz2[5:0];

  always_ff @(posedge clk_i) begin
    if (rdy[2] && v_q[1]) begin
      cmd2_q  <= cmd1_q;
      base2_q <= base1_q;
      prev2_q <= prev1_q;
      sgn2_q  <= sgn1_q;
      sp2_q   <= sp1_q;
      spv2_q  <= spv1_q;
      n2_q    <= {1'b0, p1_q, 15'd0} << lz48;
      e2_q    <= $signed({2'b0, esum1_q}) - 12'sd126 - $signed({6'b0, lz48});
    end
  end

  // stage 3: product round
  logic        cmd3_q;
  logic [31:0] base3_q, prev3_q, prod3_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3] && v_q[2]) begin
      cmd3_q  <= cmd2_q;
      base3_q <= base2_q;
      prev3_q <= prev2_q;
      prod3_q <= sp2_q ? spv2_q : aimad_pkg::round_pack(sgn2_q, e2_q, n2_q);
    end
  end

  // stage 4: add operand select, special cases and alignment
  logic [31:0] xa, xb;
  logic        sp4_d;
  logic [31:0] spv4_d;
  logic [63:0] ma4, mb4, mt4, mbs4, lost4;
  logic [7:0]  ea4, eb4, et4, d4;
  logic        sa4, sb4, st4;
  logic        sp4_q, sa4_q, sub4_q;
  logic [31:0] spv4_q;
  logic [63:0] ma4_q, mb4_q;
  logic [7:0]  ea4_q;

  always_comb begin
    xa     = cmd3_q ? prev3_q : prod3_q;
    xb     = cmd3_q ? prod3_q : base3_q;
    sp4_d  = 1'b1;
    spv4_d = xa;
    priority if (aimad_pkg::is_nan(xa)) begin
      spv4_d = xa | aimad_pkg::QUIET_BIT;
    end else if (aimad_pkg::is_nan(xb)) begin
      spv4_d = xb | aimad_pkg::QUIET_BIT;
    end else if (aimad_pkg::is_inf(xa)) begin
      spv4_d = (aimad_pkg::is_inf(xb) && xa[31] != xb[31]) ? aimad_pkg::QNAN_DEFAULT : xa;
    end else if (aimad_pkg::is_inf(xb)) begin
      spv4_d = xb;
    end else if (aimad_pkg::is_zero(xa) && aimad_pkg::is_zero(xb)) begin
      spv4_d = {xa[31] & xb[31], 31'd0};
    end else if (aimad_pkg::is_zero(xa)) begin
      spv4_d = xb;
    end else if (aimad_pkg::is_zero(xb)) begin
      spv4_d = xa;
    end else begin
      sp4_d = 1'b0;
    end

    ma4 = {2'b0, xa[30:23] != 8'd0, xa[22:0], 38'd0};
    mb4 = {2'b0, xb[30:23] != 8'd0, xb[22:0], 38'd0};
    ea4 = (xa[30:23] == 8'd0) ? 8'd1 : xa[30:23];
    eb4 = (xb[30:23] == 8'd0) ? 8'd1 : xb[30:23];
    sa4 = xa[31];
    sb4 = xb[31];
    mt4 = 64'd0;
    et4 = 8'd0;
    st4 = 1'b0;
    if (ea4 < eb4 || (ea4 == eb4 && ma4 < mb4)) begin
      mt4 = ma4; ma4 = mb4; mb4 = mt4;
      et4 = ea4; ea4 = eb4; eb4 = et4;
      st4 = sa4; sa4 = sb4; sb4 = st4;
    end
    d4    = ea4 - eb4;
    lost4 = 64'd0;
    mbs4  = mb4;
    if (d4 >= 8'd63) begin
      mbs4 = 64'd1;
    end else if (d4 != 8'd0) begin
      lost4 = mb4 & ((64'd1 << d4[5:0]) - 64'd1);
      mbs4  = (mb4 >> d4[5:0]) | {63'd0, lost4 != 64'd0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4] && v_q[3]) begin
      sp4_q  <= sp4_d;
      spv4_q <= spv4_d;
      sa4_q  <= sa4;
      sub4_q <= sa4 != sb4;
      ma4_q  <= ma4;
      mb4_q  <= mbs4;
      ea4_q  <= ea4;
    end
  end

  // stage 5: add or subtract
  logic        sp5_q, sgn5_q;
  logic [31:0] spv5_q;
  logic [63:0] sum5_q;
  logic [7:0]  ea5_q;

  always_ff @(posedge clk_i) begin
    if (rdy[5] && v_q[4]) begin
      sp5_q  <= sp4_q;
      spv5_q <= spv4_q;
      ea5_q  <= ea4_q;
      sum5_q <= sub4_q ? (ma4_q - mb4_q) : (ma4_q + mb4_q);
      // exact cancellation gives plus zero
      sgn5_q <= (sub4_q && ma4_q == mb4_q) ? 1'b0 : sa4_q;
    end
  end

  // stage 6: sum normalize
  logic [6:0]         lz6;
  logic               sp6_q, sgn6_q;
  logic [31:0]        spv6_q;
  logic [63:0]        n6_q;
  logic signed [11:0] e6_q;

  assign lz6 = aimad_pkg::lzc64(sum5_q);

  always_ff @(posedge clk_i) begin
    if (rdy[6] && v_q[5]) begin
      sp6_q  <= sp5_q;
      spv6_q <= spv5_q;
      sgn6_q <= sgn5_q;
      n6_q   <= sum5_q << (lz6 - 7'd1);
      e6_q   <= $signed({4'b0, ea5_q}) + 12'sd2 - $signed({5'b0, lz6});
    end
  end

  // stage 7: sum round
  logic [31:0] res7_q;

  always_ff @(posedge clk_i) begin
    if (rdy[7] && v_q[6]) begin
      res7_q <= sp6_q ? spv6_q : aimad_pkg::round_pack(sgn6_q, e6_q, n6_q);
    end
  end

  assign result_o = res7_q;

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Regression for attribute_interp_mul_add_core: directed binary32 corner
// cases, then random interpolation passes, checked against a bit-exact
// software model of the rounded multiply followed by the rounded add.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CMD_PASS_ONE = 1'b0;
  localparam logic CMD_PASS_TWO = 1'b1;
  localparam logic [31:0] NAN_DEFAULT = 32'h7FC0_0000;

  int unsigned err_cnt = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  function automatic bit fp_nan(input logic [31:0] x);
    return x[30:0] > 31'h7F80_0000;
  endfunction
  function automatic bit fp_inf(input logic [31:0] x);
    return x[30:0] == 31'h7F80_0000;
  endfunction
  function automatic bit fp_zero(input logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  function automatic logic [63:0] unpack_sig(input logic [31:0] x, output int ex);
    if (x[30:23] == 8'd0) begin
      ex = 1;
      return {41'd0, x[22:0]};
    end
    ex = x[30:23];
    return {40'd0, 1'b1, x[22:0]};
  endfunction

  // value is sig * 2^(ex-150)
  function automatic logic [31:0] pack_rne(input logic sg, input int ex,
                                           input logic [63:0] sig);
    int e;
    int sh;
    logic [63:0] m, rem, half;
    if (sig == 0) return {sg, 31'd0};
    while (sig[63:62] == 2'b00) begin
      sig = sig << 1;
      ex--;
    end
    e = ex + 39;
    if (e >= 1) sh = 39;
    else begin
      if (e < -23) return {sg, 31'd0};
      sh = 40 - e;
      if (sh >= 64) return {sg, 31'd0};
    end
    m = sig >> sh;
    rem = sig & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && m[0])) m++;
    if (e < 1) return {sg, m[30:0]};
    if (m >= (64'd1 << 24)) begin
      m = m >> 1;
      e++;
    end
    if (e >= 255) return {sg, 31'h7F80_0000};
    return {sg, e[7:0], m[22:0]};
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    int ea, eb;
    logic [63:0] ma, mb;
    logic sg;
    sg = a[31] ^ b[31];
    if (fp_nan(a)) return a | 32'h0040_0000;
    if (fp_nan(b)) return b | 32'h0040_0000;
    if (fp_inf(a) || fp_inf(b)) begin
      if (fp_zero(a) || fp_zero(b)) return NAN_DEFAULT;
      return {sg, 31'h7F80_0000};
    end
    if (fp_zero(a) || fp_zero(b)) return {sg, 31'd0};
    ma = unpack_sig(a, ea);
    mb = unpack_sig(b, eb);
    return pack_rne(sg, ea + eb - 150, ma * mb);
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    int ea, eb, te;
    int unsigned d;
    logic [63:0] ma, mb, tm, lost;
    logic sa, sb, ts;
    sa = a[31];
    sb = b[31];
    if (fp_nan(a)) return a | 32'h0040_0000;
    if (fp_nan(b)) return b | 32'h0040_0000;
    if (fp_inf(a)) begin
      if (fp_inf(b) && sa != sb) return NAN_DEFAULT;
      return a;
    end
    if (fp_inf(b)) return b;
    if (fp_zero(a) && fp_zero(b)) return {sa & sb, 31'd0};
    if (fp_zero(a)) return b;
    if (fp_zero(b)) return a;
    ma = unpack_sig(a, ea) << 38;
    mb = unpack_sig(b, eb) << 38;
    if (ea < eb || (ea == eb && ma < mb)) begin
      tm = ma; te = ea; ts = sa;
      ma = mb; ea = eb; sa = sb;
      mb = tm; eb = te; sb = ts;
    end
    d = ea - eb;
    if (d >= 63) mb = 64'd1;
    else if (d > 0) begin
      lost = mb & ((64'd1 << d) - 1);
      mb = (mb >> d) | (lost != 0);
    end
    if (sa == sb) return pack_rne(sa, ea - 38, ma + mb);
    if (ma == mb) return 32'd0;
    return pack_rne(sa, ea - 38, ma - mb);
  endfunction

  function automatic logic [31:0] interp_value(input logic cmd, input logic [31:0] s,
      input logic [31:0] base, input logic [31:0] coef, input logic [31:0] prev);
    logic [31:0] prod;
    prod = fp_mul(coef, s);
    return (cmd == CMD_PASS_ONE) ? fp_add(prod, base) : fp_add(prev, prod);
  endfunction

  class interp_scoreboard;
    logic [31:0] pending_q[$];
    function void note_input(logic cmd, logic [31:0] s, logic [31:0] base,
                             logic [31:0] coef, logic [31:0] prev);
      pending_q.push_back(interp_value(cmd, s, base, coef, prev));
    endfunction
    task check_result(logic [31:0] res);
      logic [31:0] want;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", res));
        return;
      end
      want = pending_q.pop_front();
      if (res !== want)
        report_mismatch($sformatf("result %h, expected %h", res, want));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic        command_i = 1'b0;
  logic [31:0] bary_s_i = '0;
  logic [31:0] attr_base_i = '0;
  logic [31:0] attr_coef_i = '0;
  logic [31:0] dest_prev_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [31:0] result_o;

  bit idle_en = 1'b1;
  interp_scoreboard sb = new();

  attribute_interp_mul_add_core i_dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #200000;
    $display("attribute_interp_mul_add_core regression: fail");
    $finish;
  end

  // result side: random stall, check each transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o && !stall_i) sb.check_result(result_o);
      stall_i <= idle_en ? ($urandom_range(99) < 37) : 1'b0;
    end
  end

  task automatic send_item(input logic cmd, input logic [31:0] s, input logic [31:0] base,
                           input logic [31:0] coef, input logic [31:0] prev);
    while (idle_en && $urandom_range(99) < 37) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    command_i <= cmd;
    bary_s_i <= s;
    attr_base_i <= base;
    attr_coef_i <= coef;
    dest_prev_i <= prev;
    do @(posedge clk_i); while (stall_o);
    sb.note_input(cmd, s, base, coef, prev);
  endtask

  function automatic logic [31:0] rand_fp();
    case ($urandom_range(9))
      0: return {1'($urandom), 8'hFF, 23'($urandom)};
      1: return {1'($urandom), 8'h00, 23'($urandom)};
      2: return {1'($urandom), 8'($urandom_range(1, 2)), 23'($urandom)};
      3: return {1'($urandom), 8'($urandom_range(240, 254)), 23'($urandom)};
      4: return {1'($urandom), 31'h7F80_0000};
      5: return {1'($urandom), 31'd0};
      6: return $urandom;
      default: return {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
    endcase
  endfunction

  initial begin
    logic [31:0] dir_val[14] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
      32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001, 32'hFFBF_FFFF, 32'h0000_0001,
      32'h807F_FFFF, 32'h7F7F_FFFF, 32'hFFFF_FFFF, 32'h3F80_0000, 32'h0080_0000,
      32'h3F00_0000};
    logic [31:0] s, c, p;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // operand extremes, nan precedence, opposite infinities
    for (int i = 0; i < 10; i++)
      send_item(1'(i), dir_val[i], dir_val[13 - i], dir_val[(i + 5) % 14], dir_val[i + 4]);
    send_item(CMD_PASS_ONE, 32'h7F80_0000, 32'h7F80_0000, 32'h3F80_0000, 32'h0);
    send_item(CMD_PASS_TWO, 32'h3F80_0000, 32'h0, 32'hFF80_0000, 32'h7F80_0000);
    send_item(CMD_PASS_ONE, 32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0000, 32'h0);
    send_item(CMD_PASS_TWO, 32'h3F80_0000, 32'h0, 32'h8000_0000, 32'h8000_0000);
    send_item(CMD_PASS_ONE, 32'h7FA0_0000, 32'h7FB0_0000, 32'hFF90_0000, 32'h7F80_0001);
    send_item(CMD_PASS_TWO, 32'h7F7F_FFFF, 32'h0, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
    send_item(CMD_PASS_ONE, 32'h0000_0003, 32'h8000_0001, 32'h3F00_0000, 32'h0);
    // drain fully before carrying on
    valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    for (int n = 0; n < 600; n++) begin
      idle_en = !(n >= 200 && n < 300);
      s = ($urandom_range(3) == 0) ? rand_fp() : {2'b00, 8'($urandom_range(100, 126)),
                                                  22'($urandom)};
      c = rand_fp();
      p = rand_fp();
      // sometimes make the add cancel
      if ($urandom_range(9) == 0) p = fp_mul(c, s) ^ 32'h8000_0000;
      send_item(1'($urandom), s, rand_fp(), c, p);
    end
    valid_i <= 1'b0;
    idle_en = 1'b1;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) $display("attribute_interp_mul_add_core regression: pass");
    else $display("attribute_interp_mul_add_core regression: fail");
    $finish;
  end
endmodule
